@@ rtl/dclru_pkg.sv @@
// dclru_pkg: shared types and constants of the 8-way lru data cache
// used by the controller, the datapath and the top level
package dclru_pkg;

  // tag width of the original address split
  localparam int unsigned TAG_LIMIT = 19;

  // age counter of the most recently used way
  localparam logic [2:0] AGE_TOP = 3'd7;

  // register reset values
  localparam logic [31:0] FILL_RESET    = 32'h1234_1234;
  localparam logic [7:0]  PENALTY_RESET = 8'd50;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register byte addresses
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_FILL    = 3'd0;
  localparam logic [PADDR_W-1:0] REG_PENALTY = 3'd4;

  // controller states
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_FILL   = 5'b01000,
    S_RESP   = 5'b10000
  } dclru_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic lookup;
    logic fill_wr;
    logic resp_load;
  } dclru_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic hit;
    logic fill_last;
    logic out_busy;
  } dclru_sts_t;

endpackage

@@ rtl/dclru_ram.sv @@
// dclru_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module dclru_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/dclru_ctrl.sv @@
// dclru_ctrl: sequencing state machine of the lru data cache
// depends on dclru_pkg
module dclru_ctrl
  import dclru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dclru_sts_t sts,
  output dclru_cmd_t cmd
);

  dclru_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = sts.hit ? S_RESP : S_FILL;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_next = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ rtl/dclru_dp.sv @@
// dclru_dp: tag/age row store, line data store, hit and victim logic, result register
// depends on dclru_pkg and dclru_ram
module dclru_dp
  import dclru_pkg::*;
#(
  parameter int unsigned NUM_SETS   = 256,
  parameter int unsigned NUM_WAYS   = 8,
  parameter int unsigned LINE_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  dclru_cmd_t  cmd,
  output dclru_sts_t  sts,
  input  logic        operation,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [31:0] fill_word,
  input  logic [7:0]  miss_penalty,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] read_data,
  output logic        hit,
  output logic        writeback_needed,
  output logic [31:0] elapsed_time
);

  localparam int unsigned OB   = $clog2(LINE_WORDS);
  localparam int unsigned SB   = $clog2(NUM_SETS);
  localparam int unsigned WB   = $clog2(NUM_WAYS);
  localparam int unsigned FREE = 30 - OB - SB;
  localparam int unsigned TW   = (FREE < TAG_LIMIT) ? FREE : TAG_LIMIT;
  localparam int unsigned EW   = TW + 5;
  localparam int unsigned RW   = NUM_WAYS * EW;
  localparam int unsigned DAW  = SB + WB + OB;

  // registered item
  logic          op_r;
  logic [OB-1:0] word_r;
  logic [SB-1:0] set_r;
  logic [TW-1:0] tag_r;
  logic [31:0]   wdata_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= operation;
      word_r  <= address[2 +: OB];
      set_r   <= address[2+OB +: SB];
      tag_r   <= address[2+OB+SB +: TW];
      wdata_r <= write_data;
    end
  end

  // tag / state row store
  logic [RW-1:0] row_rd, row_new;
  logic          tag_we;
  logic [SB-1:0] tag_waddr, clr_cnt;

  assign tag_we    = cmd.clear_wr | cmd.lookup;
  assign tag_waddr = cmd.clear_wr ? clr_cnt : set_r;

  dclru_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (cmd.clear_wr ? {RW{1'b0}} : row_new),
    .re    (cmd.accept),
    .raddr (address[2+OB +: SB]),
    .rdata (row_rd)
  );

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // unpack the row
  logic [TW-1:0] e_tag   [NUM_WAYS];
  logic          e_valid [NUM_WAYS];
  logic          e_dirty [NUM_WAYS];
  logic [2:0]    e_age   [NUM_WAYS];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      e_tag[w]   = row_rd[w*EW +: TW];
      e_valid[w] = row_rd[w*EW + TW];
      e_dirty[w] = row_rd[w*EW + TW + 1];
      e_age[w]   = row_rd[w*EW + TW + 2 +: 3];
    end
  end

  // hit search, victim choice and the updated row
  logic          hit_c, wb_c;
  logic [WB-1:0] hway_c, vway_c, way_c;
  logic [2:0]    best;

  always_comb begin
    hit_c  = 1'b0;
    hway_c = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (e_valid[w] && e_tag[w] == tag_r) begin
        hit_c  = 1'b1;
        hway_c = WB'(w);
      end
    end
    best   = AGE_TOP;
    vway_c = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (e_age[w] < best) begin
        best   = e_age[w];
        vway_c = WB'(w);
      end
    end
    way_c = hit_c ? hway_c : vway_c;
    wb_c  = !hit_c && e_valid[vway_c] && e_dirty[vway_c];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WB'(w) == way_c) begin
        row_new[w*EW +: TW]        = hit_c ? e_tag[w] : tag_r;
        row_new[w*EW + TW]         = 1'b1;
        row_new[w*EW + TW + 1]     = hit_c ? (e_dirty[w] | op_r) : op_r;
        row_new[w*EW + TW + 2 +: 3] = AGE_TOP;
      end else begin
        row_new[w*EW +: TW]        = e_tag[w];
        row_new[w*EW + TW]         = e_valid[w];
        row_new[w*EW + TW + 1]     = e_dirty[w];
        row_new[w*EW + TW + 2 +: 3] = (e_age[w] != 3'd0) ? e_age[w] - 3'd1 : e_age[w];
      end
    end
  end

  // lookup outcome and refill word counter
  logic          hit_r, wb_r;
  logic [WB-1:0] way_r;
  logic [OB-1:0] fill_cnt;
  logic [31:0]   elapsed;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r <= hit_c;
      wb_r  <= wb_c;
      way_r <= way_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      fill_cnt <= '0;
    end else if (cmd.fill_wr) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // wrapping miss time
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (cmd.lookup && !hit_c) begin
      elapsed <= elapsed + 32'(miss_penalty);
    end
  end

  // line data store: hit access during lookup, refill sweep afterwards
  logic [DAW-1:0] d_addr;
  logic           d_we;
  logic [31:0]    d_wdata, d_rdata;

  assign d_addr  = cmd.lookup ? {set_r, way_c, word_r} : {set_r, way_r, fill_cnt};
  assign d_we    = (cmd.lookup && hit_c && op_r == OP_WRITE) || cmd.fill_wr;
  assign d_wdata = (cmd.fill_wr && !(op_r == OP_WRITE && fill_cnt == word_r))
                   ? fill_word : wdata_r;

  dclru_ram #(.WIDTH(32), .DEPTH(2**DAW)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_addr),
    .wdata (d_wdata),
    .re    (cmd.lookup),
    .raddr (d_addr),
    .rdata (d_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      read_data        <= (op_r == OP_WRITE) ? wdata_r : (hit_r ? d_rdata : fill_word);
      hit              <= hit_r;
      writeback_needed <= wb_r;
      elapsed_time     <= elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // status
  assign sts.clear_last = (clr_cnt == SB'(NUM_SETS - 1));
  assign sts.hit        = hit_c;
  assign sts.fill_last  = (fill_cnt == OB'(LINE_WORDS - 1));
  assign sts.out_busy   = out_valid && out_stall;

  // a hit never evicts
  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup && hit_c |-> !wb_c)
    else $error("writeback flagged on a hit");

  // a miss adds the penalty to the time counter
  a_miss_time: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup && !hit_c |=> elapsed == $past(elapsed) + 32'($past(miss_penalty)))
    else $error("miss time not accumulated");

  // a loaded result is presented
  a_resp_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.resp_load |=> out_valid)
    else $error("loaded result not valid");

endmodule

@@ rtl/data_cache_lru_8way.sv @@
// data_cache_lru_8way: top level of the 8-way write-back lru data cache
// depends on dclru_pkg, dclru_ctrl, dclru_dp and dclru_ram
//
// One read or write of one word per item, one result per item. After reset a
// clearing pass writes every set's tag row, during which no item is accepted.
// A hit goes through tag row read at acceptance, lookup with data access and
// result load; a miss adds a refill after the lookup, which writes the line
// one word per cycle through the single data memory write port. The next item
// is accepted once the result is loaded into the output register, even while
// that result is still stalled.
module data_cache_lru_8way
  import dclru_pkg::*;
#(
  parameter int unsigned NUM_SETS   = 256,
  parameter int unsigned NUM_WAYS   = 8,
  parameter int unsigned LINE_WORDS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [31:0]        address,
  input  logic [31:0]        write_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        read_data,
  output logic               hit,
  output logic               writeback_needed,
  output logic [31:0]        elapsed_time
);

  logic [31:0] fill_word;
  logic [7:0]  miss_penalty;
  logic        cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_word    <= FILL_RESET;
      miss_penalty <= PENALTY_RESET;
    end else if (cfg_wr) begin
      case (paddr)
        REG_FILL:    fill_word    <= pwdata;
        REG_PENALTY: miss_penalty <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_FILL:    prdata = fill_word;
      REG_PENALTY: prdata = {24'd0, miss_penalty};
      default:     prdata = '0;
    endcase
  end

  dclru_cmd_t cmd;
  dclru_sts_t sts;

  dclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dclru_dp #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_WORDS (LINE_WORDS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .operation        (operation),
    .address          (address),
    .write_data       (write_data),
    .fill_word        (fill_word),
    .miss_penalty     (miss_penalty),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .read_data        (read_data),
    .hit              (hit),
    .writeback_needed (writeback_needed),
    .elapsed_time     (elapsed_time)
  );

endmodule

@@ tb/data_cache_lru_8way_test.sv @@
// data_cache_lru_8way_test: self-checking bench for the 8-way lru data cache
// depends on dclru_pkg and data_cache_lru_8way; predicts every result in a local cache image
module data_cache_lru_8way_test;
  import dclru_pkg::*;

  localparam int unsigned SETS  = 256;
  localparam int unsigned WAYS  = 8;
  localparam int unsigned WORDS = 8;
  localparam int unsigned LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = OP_READ;
  logic [31:0]        address = '0;
  logic [31:0]        write_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        read_data;
  logic               hit;
  logic               writeback_needed;
  logic [31:0]        elapsed_time;

  data_cache_lru_8way uut (.*);

  always #5 clk = ~clk;

  // one predicted result
  typedef struct {
    logic [31:0] rdata;
    logic        hit;
    logic        wb;
    logic [31:0] etime;
  } access_result_t;

  // directed row; chk set where the result is typed in
  typedef struct {
    logic           op;
    logic [31:0]    addr;
    logic [31:0]    wdata;
    bit             chk;
    access_result_t res;
  } access_row_t;

  // local cache image
  logic [18:0] tag_img [SETS*WAYS];
  bit          vld_img [SETS*WAYS];
  bit          dty_img [SETS*WAYS];
  logic [2:0]  age_img [SETS*WAYS];
  logic [31:0] word_img [SETS*WAYS*WORDS];
  logic [31:0] time_img;
  logic [31:0] fill_img;
  logic [7:0]  penalty_img;

  access_result_t pending_results[$];
  int errors = 0;
  int accesses = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int wb_seen = 0;
  int cycles = 0;
  bit idle_rx = 1'b1;
  bit idle_tx = 1'b1;
  bit hold_rx = 1'b0;
  bit done_tx = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  // compute the result of one access and update the image
  function automatic access_result_t predict_access(logic op, logic [31:0] addr,
                                                    logic [31:0] wdata);
    access_result_t r;
    int unsigned wsel, set, base, way, slot;
    logic [18:0] tag;
    logic [2:0] best;
    bit found;
    wsel = addr[4:2];
    set = addr[12:5];
    tag = addr[31:13];
    base = set * WAYS;
    way = 0;
    found = 0;
    best = AGE_TOP;
    r.wb = 1'b0;
    for (int w = 0; w < WAYS; w++)
      if (!found && vld_img[base+w] && tag_img[base+w] == tag) begin
        found = 1;
        way = w;
      end
    if (!found) begin
      for (int w = 0; w < WAYS; w++)
        if (age_img[base+w] < best) begin
          best = age_img[base+w];
          way = w;
        end
      r.wb = vld_img[base+way] && dty_img[base+way];
      vld_img[base+way] = 1;
      dty_img[base+way] = 0;
      tag_img[base+way] = tag;
      for (int k = 0; k < WORDS; k++) word_img[(base+way)*WORDS+k] = fill_img;
      time_img += penalty_img;
    end
    // age the set
    for (int w = 0; w < WAYS; w++)
      if (w == way) age_img[base+w] = AGE_TOP;
      else if (age_img[base+w] != 0) age_img[base+w]--;
    slot = (base + way) * WORDS + wsel;
    if (op == OP_WRITE) begin
      word_img[slot] = wdata;
      dty_img[base+way] = 1;
    end
    r.rdata = word_img[slot];
    r.hit = found;
    r.etime = time_img;
    return r;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_access(logic op, logic [31:0] addr, logic [31:0] wdata,
                             bit chk, access_result_t want);
    access_result_t p;
    while (idle_tx && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= addr;
    write_data <= wdata;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_access(op, addr, wdata);
    if (chk && (p.rdata !== want.rdata || p.hit !== want.hit ||
        p.wb !== want.wb || p.etime !== want.etime))
      report("typed-in row", p.etime, want.etime);
    pending_results.push_back(p);
    accesses++;
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] a, logic [31:0] d);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == REG_FILL) fill_img = d;
    else penalty_img = d[7:0];
    @(posedge clk);
  endtask

  // wait for all results, then a wait longer than a miss
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 + WORDS + 4) @(posedge clk);
  endtask

  // address builder: tag, set, word
  function automatic logic [31:0] mk_addr(logic [18:0] t, logic [7:0] s, logic [2:0] w);
    return {t, s, w, 2'b00};
  endfunction

  // receiver: random stall, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_rx || (idle_rx && $urandom_range(99) < 33);
  end

  // result checker
  always @(posedge clk) begin
    access_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) report("unexpected result", read_data, 0);
      else begin
        e = pending_results.pop_front();
        if (read_data !== e.rdata) report("read_data", read_data, e.rdata);
        if (hit !== e.hit) report("hit", hit, e.hit);
        if (writeback_needed !== e.wb) report("writeback_needed", writeback_needed, e.wb);
        if (elapsed_time !== e.etime) report("elapsed_time", elapsed_time, e.etime);
        hits_seen += hit;
        wb_seen += writeback_needed;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long receiver hold-off, counted in the hold_off task below
  initial begin
    wait (done_tx);
  end

  task automatic hold_off(int n);
    hold_rx = 1'b1;
    repeat (n) @(posedge clk);
    hold_rx = 1'b0;
  endtask

  initial begin
    access_row_t rows[$];
    access_result_t z;
    logic [18:0] tags[8];
    logic [7:0] sets[4];
    int n;
    for (int i = 0; i < SETS*WAYS; i++) begin
      tag_img[i] = '0; vld_img[i] = 0; dty_img[i] = 0; age_img[i] = '0;
    end
    foreach (word_img[i]) word_img[i] = '0;
    time_img = '0;
    fill_img = FILL_RESET;
    penalty_img = PENALTY_RESET;
    z = '{default: '0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table: reset fill, extremes, write hit/miss, eviction of dirty lines
    rows.push_back('{OP_READ, 32'h0000_0000, 32'h0, 1, '{FILL_RESET, 0, 0, 32'd50}});
    rows.push_back('{OP_READ, 32'h0000_0004, 32'h0, 1, '{FILL_RESET, 1, 0, 32'd50}});
    rows.push_back('{OP_WRITE, 32'h0000_001C, 32'hFFFF_FFFF, 1,
                     '{32'hFFFF_FFFF, 1, 0, 32'd50}});
    rows.push_back('{OP_WRITE, 32'hFFFF_FFFF, 32'h0, 1, '{32'h0, 0, 0, 32'd100}});
    rows.push_back('{OP_READ, 32'hFFFF_FFFC, 32'h0, 1, '{32'h0, 1, 0, 32'd100}});
    rows.push_back('{OP_READ, 32'h0000_001C, 32'h0, 0, z});
    // fill set 0 with eight dirty ways, then force evictions
    for (int i = 1; i < 10; i++)
      rows.push_back('{OP_WRITE, mk_addr(19'(i), 8'd0, 3'(i)), 32'hA5A5_0000 + 32'(i), 0, z});
    for (int i = 0; i < 8; i++)
      rows.push_back('{OP_READ, mk_addr(19'(19'h7FFFF - 19'(i)), 8'd0, 3'(i)), 32'h0, 0, z});
    foreach (rows[i]) send_access(rows[i].op, rows[i].addr, rows[i].wdata,
                                  rows[i].chk, rows[i].res);
    drain();

    // configuration phases, with extremes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_FILL, 32'h0); write_reg(REG_PENALTY, 32'h0); end
        1: begin write_reg(REG_FILL, 32'hFFFF_FFFF); write_reg(REG_PENALTY, 32'hFF); end
        2: begin write_reg(REG_FILL, $urandom); write_reg(REG_PENALTY, $urandom); end
        default: begin
          write_reg(REG_FILL, $urandom);
          write_reg(REG_PENALTY, $urandom_range(255));
        end
      endcase
      idle_rx = (ph != 3);
      idle_tx = (ph != 3);
      // a small working set per phase gives hits, evictions and writebacks
      foreach (tags[i]) tags[i] = 19'($urandom);
      foreach (sets[i]) sets[i] = 8'($urandom);
      n = 0;
      fork
        if (ph == 4) begin
          repeat (20) @(posedge clk);
          hold_off(300);
        end
        while (n < 280) begin
          logic [31:0] a;
          if ($urandom_range(9) < 8)
            a = mk_addr(tags[$urandom_range(7)] ^ ($urandom_range(3) == 0 ? 19'd8 : 19'd0),
                        sets[$urandom_range(3)], 3'($urandom));
          else a = $urandom;
          send_access(1'($urandom), a, $urandom, 0, z);
          n++;
        end
      join
      drain();
    end
    idle_rx = 1'b1;
    done_tx = 1'b1;

    $display("%0d accesses, %0d results, %0d hits, %0d writebacks over six settings",
             accesses, results_seen, hits_seen, wb_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
